// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Plain invariant
`define ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

// ----- rtl/fusc_pkg.sv -----
// Package for the firmware update session checker: types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package fusc_pkg;
    localparam int BLOCK_BYTES_DEF = 256;
    localparam int SIZE_BITS_DEF   = 20;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [20:0] MAX_SIZE_RST = 21'd229376;
    localparam logic [31:0] TIMEOUT_RST  = 32'd30000;
    localparam logic [19:0] PBASE_RST    = 20'd229376;

    typedef enum logic [2:0] {
        OP_START = 3'd0, OP_WRITE = 3'd1, OP_VERIFY = 3'd2, OP_ABORT = 3'd3, OP_TICK = 3'd4
    } op_t;
    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_TOO_LARGE = 3'd1, ST_BUSY = 3'd2, ST_WRONG_STATE = 3'd3,
        ST_BAD_BLOCK = 3'd4, ST_FLASH_FAIL = 3'd5, ST_CRC_MISMATCH = 3'd6
    } status_t;
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0, PH_RECV = 3'd1, PH_VERIFY = 3'd2, PH_DONE = 3'd3, PH_ERR = 3'd4
    } phase_t;
    typedef enum logic [1:0] {
        FLT_NONE = 2'd0, FLT_FLASH = 2'd1, FLT_CRC = 2'd2, FLT_TIMEOUT = 2'd3
    } fault_t;
    typedef enum logic [1:0] {
        CFG_MAX_SIZE = 2'd0, CFG_TIMEOUT = 2'd1, CFG_PBASE = 2'd2
    } cfg_idx_t;
    typedef enum logic [1:0] {
        C_IDLE, C_EXEC, C_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now_ms;
        logic [19:0] image_size;
        logic [31:0] expected_crc;
        logic [11:0] block_index;
        logic [8:0]  block_length;
        logic        flash_failed;
        logic [7:0]  image_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  session_phase;
        logic [7:0]  progress_percent;
        logic [1:0]  fault_code;
        logic [20:0] flash_address;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;       // apply the held item to the session state
        logic div_start;  // load the progress divider
        logic div_step;   // one restoring step
        logic load_out;   // capture the finished result in the output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } dp_stat_t;
endpackage

// ----- rtl/firmware_update_session_checker.sv -----
// Firmware update session checker: a single beat on the input channel gives
// one result beat on the output channel.
// Channels: in (valid/ready, in_item_t), out (valid/ready, out_item_t), and
// cfg (valid/ready, register index and data) for the three settings.
// An accepted item is applied in the execute state, then the progress
// percentage is produced by a restoring divider that takes one quotient
// bit a cycle; the result is then loaded into the output register. The
// input is ready again in the cycle after that load, so a new item is
// taken only once the previous one is through.
// If the receiver stalls, the result is held in the output register; one
// more item can be taken and worked through, then it waits with the input
// closed until the output register frees.
// Reset puts the session in idle with cleared counters, CRC preset to all
// ones and the settings at their defaults. Configuration is accepted at any
// time but is meant to be written only while the block is idle.
// Depends on fusc_pkg, fusc_ctrl, fusc_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module firmware_update_session_checker #(
    parameter int BLOCK_BYTES = fusc_pkg::BLOCK_BYTES_DEF,
    parameter int SIZE_BITS   = fusc_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fusc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fusc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  fusc_pkg::cfg_beat_t cfg_data
);
    fusc_pkg::dp_cmd_t  cmd;
    fusc_pkg::dp_stat_t stat;
    logic               in_take;
    logic               out_stall;

    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    fusc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    fusc_dp #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .SIZE_BITS   (SIZE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .in_item  (in_data),
        .cfg_take (cfg_valid && cfg_ready),
        .cfg_item (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .result   (out_data)
    );

    `ASSERT_IMPL(a_accept_then_exec, clk, rst_n, in_take |=> cmd.exec, "item without execute")
    `ASSERT_IMPL(a_no_ready_busy, clk, rst_n, !(in_ready && cmd.div_step), "ready while dividing")
    `ASSERT_IMPL(a_out_held, clk, rst_n, out_stall |=> $stable(out_data), "held result changed")
endmodule

// ----- rtl/fusc_ctrl.sv -----
// Sequencer for one item: execute, divide for progress, present result.
// Depends on fusc_pkg.
`timescale 1ns / 1ps
module fusc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output fusc_pkg::dp_cmd_t   cmd,
    input  fusc_pkg::dp_stat_t  stat
);
    fusc_pkg::ctrl_state_t state_reg, state_next;
    logic                  out_full_reg, out_full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fusc_pkg::C_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign out_valid = out_full_reg;

    always_comb
    begin
        state_next = state_reg;
        out_full_next = out_full_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (out_full_reg && out_ready)
            out_full_next = 1'b0;
        unique case (state_reg)
            fusc_pkg::C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = fusc_pkg::C_EXEC;
            end
            fusc_pkg::C_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = fusc_pkg::C_DIV;
            end
            fusc_pkg::C_DIV:
            begin
                if (!stat.div_done)
                    cmd.div_step = 1'b1;
                // output register may be refilled in the cycle its beat leaves
                else if (!out_full_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    out_full_next = 1'b1;
                    state_next = fusc_pkg::C_IDLE;
                end
            end
            default: state_next = fusc_pkg::C_IDLE;
        endcase
        cmd.div_start = cmd.exec;
    end
endmodule

// ----- rtl/fusc_dp.sv -----
// Session state, CRC, address and restoring progress divider.
// Depends on fusc_pkg; driven by fusc_ctrl commands.
`timescale 1ns / 1ps
module fusc_dp #(
    parameter int BLOCK_BYTES = fusc_pkg::BLOCK_BYTES_DEF,
    parameter int SIZE_BITS   = fusc_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_take,
    input  fusc_pkg::in_item_t  in_item,
    input  logic                cfg_take,
    input  fusc_pkg::cfg_beat_t cfg_item,
    input  fusc_pkg::dp_cmd_t   cmd,
    output fusc_pkg::dp_stat_t  stat,
    output fusc_pkg::out_item_t result
);
    localparam int BB_BITS  = $clog2(BLOCK_BYTES);
    localparam int BLK_BITS = SIZE_BITS - BB_BITS + 1;
    localparam int RECV_W   = SIZE_BITS + 1;
    localparam int NUM_W    = 23;   // 65535*100 fits
    localparam logic [RECV_W-1:0]    RECV_MAX = {RECV_W{1'b1}};
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

    logic [20:0] max_size_reg;
    logic [31:0] timeout_reg;
    logic [19:0] pbase_reg;

    fusc_pkg::in_item_t   item_reg;
    fusc_pkg::phase_t     phase_reg;
    fusc_pkg::fault_t     fault_reg;
    logic [SIZE_BITS-1:0] total_bytes_reg;
    logic [31:0]          wanted_crc_reg;
    logic [BLK_BITS-1:0]  blk_cnt_reg;
    logic [RECV_W-1:0]    bytes_rx_reg;
    logic [15:0]          blocks_rx_reg;
    logic [31:0]          last_ms_reg;
    logic [31:0]          crc_reg;
    logic [SIZE_BITS-1:0] verified_reg;
    fusc_pkg::status_t    status_reg;
    logic [20:0]          addr_reg;

    logic [NUM_W-1:0]    quo_reg;
    logic [BLK_BITS:0]   rem_reg;
    logic [4:0]          div_cnt_reg;

    fusc_pkg::out_item_t result_next;
    fusc_pkg::out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= fusc_pkg::MAX_SIZE_RST;
            timeout_reg  <= fusc_pkg::TIMEOUT_RST;
            pbase_reg    <= fusc_pkg::PBASE_RST;
        end
        else if (cfg_take)
        begin
            unique case (cfg_item.index)
                fusc_pkg::CFG_MAX_SIZE: max_size_reg <= cfg_item.data[20:0];
                fusc_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg_item.data;
                fusc_pkg::CFG_PBASE:    pbase_reg    <= cfg_item.data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_item;
    end

    // combinational update of one item
    fusc_pkg::phase_t     phase_next;
    fusc_pkg::fault_t     fault_next;
    fusc_pkg::status_t    status_next;
    logic [SIZE_BITS-1:0] total_bytes_next;
    logic [31:0]          wanted_crc_next;
    logic [BLK_BITS-1:0]  blk_cnt_next;
    logic [RECV_W-1:0]    bytes_rx_next;
    logic [15:0]          blocks_rx_next;
    logic [31:0]          last_ms_next;
    logic [31:0]          crc_next;
    logic [SIZE_BITS-1:0] verified_next;
    logic [20:0]          addr_next;
    logic [RECV_W:0]      rx_sum;
    logic [SIZE_BITS:0]   size_ceil;
    logic [31:0]          crc_tmp;
    logic [31:0]          elapsed;
    logic [SIZE_BITS-1:0] isize;

    always_comb
    begin
        phase_next = phase_reg;
        fault_next = fault_reg;
        status_next = fusc_pkg::ST_OK;
        total_bytes_next = total_bytes_reg;
        wanted_crc_next = wanted_crc_reg;
        blk_cnt_next = blk_cnt_reg;
        bytes_rx_next = bytes_rx_reg;
        blocks_rx_next = blocks_rx_reg;
        last_ms_next = last_ms_reg;
        crc_next = crc_reg;
        verified_next = verified_reg;
        addr_next = '0;
        isize = SIZE_BITS'(item_reg.image_size);
        size_ceil = {1'b0, isize} + (SIZE_BITS+1)'(BLOCK_BYTES - 1);
        rx_sum = {1'b0, bytes_rx_reg} + (RECV_W+1)'(item_reg.block_length);
        elapsed = item_reg.now_ms - last_ms_reg;
        crc_tmp = crc_reg ^ {24'd0, item_reg.image_byte};
        for (int k = 0; k < 8; k++)
            crc_tmp = (crc_tmp >> 1) ^ (crc_tmp[0] ? fusc_pkg::CRC_POLY : 32'd0);
        unique case (item_reg.op)
            fusc_pkg::OP_START:
            begin
                if (21'(item_reg.image_size) > max_size_reg)
                    status_next = fusc_pkg::ST_TOO_LARGE;
                else if (phase_reg == fusc_pkg::PH_RECV)
                    status_next = fusc_pkg::ST_BUSY;
                else
                begin
                    phase_next = fusc_pkg::PH_RECV;
                    total_bytes_next = isize;
                    wanted_crc_next = item_reg.expected_crc;
                    blk_cnt_next = size_ceil[SIZE_BITS:BB_BITS];
                    bytes_rx_next = '0;
                    blocks_rx_next = '0;
                    last_ms_next = item_reg.now_ms;
                    fault_next = fusc_pkg::FLT_NONE;
                    crc_next = fusc_pkg::CRC_INIT;
                    verified_next = '0;
                end
            end
            fusc_pkg::OP_WRITE:
            begin
                if (phase_reg != fusc_pkg::PH_RECV)
                    status_next = fusc_pkg::ST_WRONG_STATE;
                else if (BLK_BITS'(item_reg.block_index) >= blk_cnt_reg
                         || (BLK_BITS < 12 && (item_reg.block_index >> BLK_BITS) != 12'd0))
                    status_next = fusc_pkg::ST_BAD_BLOCK;
                else
                begin
                    addr_next = 21'({1'b0, pbase_reg}
                                    + (33'(item_reg.block_index) << BB_BITS));
                    if (item_reg.flash_failed)
                    begin
                        phase_next = fusc_pkg::PH_ERR;
                        fault_next = fusc_pkg::FLT_FLASH;
                        status_next = fusc_pkg::ST_FLASH_FAIL;
                    end
                    else
                    begin
                        bytes_rx_next = rx_sum[RECV_W] ? RECV_MAX : rx_sum[RECV_W-1:0];
                        if (blocks_rx_reg != 16'hFFFF)
                            blocks_rx_next = blocks_rx_reg + 16'd1;
                        last_ms_next = item_reg.now_ms;
                        if (bytes_rx_next >= {1'b0, total_bytes_reg})
                            phase_next = fusc_pkg::PH_VERIFY;
                    end
                end
            end
            fusc_pkg::OP_VERIFY:
            begin
                if (phase_reg != fusc_pkg::PH_VERIFY)
                    status_next = fusc_pkg::ST_WRONG_STATE;
                else
                begin
                    crc_next = crc_tmp;
                    if (verified_reg != SIZE_MAX)
                        verified_next = verified_reg + 1'b1;
                    if (verified_next >= total_bytes_reg)
                    begin
                        if (~crc_tmp != wanted_crc_reg)
                        begin
                            phase_next = fusc_pkg::PH_ERR;
                            fault_next = fusc_pkg::FLT_CRC;
                            status_next = fusc_pkg::ST_CRC_MISMATCH;
                        end
                        else
                            phase_next = fusc_pkg::PH_DONE;
                    end
                end
            end
            fusc_pkg::OP_ABORT: phase_next = fusc_pkg::PH_IDLE;
            fusc_pkg::OP_TICK:
            begin
                if (phase_reg == fusc_pkg::PH_RECV && elapsed > timeout_reg)
                begin
                    phase_next = fusc_pkg::PH_ERR;
                    fault_next = fusc_pkg::FLT_TIMEOUT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fusc_pkg::PH_IDLE;
            fault_reg <= fusc_pkg::FLT_NONE;
            total_bytes_reg <= '0;
            wanted_crc_reg <= '0;
            blk_cnt_reg <= '0;
            bytes_rx_reg <= '0;
            blocks_rx_reg <= '0;
            last_ms_reg <= '0;
            crc_reg <= fusc_pkg::CRC_INIT;
            verified_reg <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
            fault_reg <= fault_next;
            total_bytes_reg <= total_bytes_next;
            wanted_crc_reg <= wanted_crc_next;
            blk_cnt_reg <= blk_cnt_next;
            bytes_rx_reg <= bytes_rx_next;
            blocks_rx_reg <= blocks_rx_next;
            last_ms_reg <= last_ms_next;
            crc_reg <= crc_next;
            verified_reg <= verified_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            addr_reg <= addr_next;
        end
    end

    // restoring divider: blocks*100 / block count, one quotient bit a cycle
    logic [NUM_W-1:0]  dividend;
    logic [BLK_BITS+1:0] rem_try;
    logic [BLK_BITS:0]   rem_shift;

    assign dividend = NUM_W'({blocks_rx_next, 6'd0}) + NUM_W'({blocks_rx_next, 5'd0})
                    + NUM_W'({blocks_rx_next, 2'd0});
    assign rem_shift = {rem_reg[BLK_BITS-1:0], quo_reg[NUM_W-1]};
    assign rem_try = {1'b0, rem_shift} - {2'b00, blk_cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_start)
            div_cnt_reg <= 5'(NUM_W);
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_try[BLK_BITS+1])
            begin
                rem_reg <= rem_try[BLK_BITS:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign stat.div_done = (div_cnt_reg == 5'd0);

    always_comb
    begin
        result_next.status = status_reg;
        result_next.session_phase = phase_reg;
        result_next.fault_code = fault_reg;
        result_next.flash_address = addr_reg;
        if (blk_cnt_reg == '0)
            result_next.progress_percent = 8'd0;
        else if (quo_reg > NUM_W'(255))
            result_next.progress_percent = 8'hFF;
        else
            result_next.progress_percent = quo_reg[7:0];
    end

    // output register: frees the session state for the next item
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            result_reg <= result_next;
    end

    assign result = result_reg;
endmodule
